// ===== hdl/srtf_pkg.sv =====
// Shared types, sizes and helpers for the shortest-remaining-time-first scheduler.
// Used by srtf_slot_ram, srtf_engine and srtf_preemptive_scheduler_core.
// No dependencies.
`default_nettype none

package srtf_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TIME_W    = 16;
  localparam int PID_W     = 5;
  localparam int SUM_W     = 32;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_ZERO_BURST = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [PID_W-1:0]  process_id;
    logic [TIME_W-1:0] tick_time;
    logic              new_segment;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [PID_W-1:0]  done_count;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic              done;
  } slot_entry_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [IDX_W-1:0]  addr;
    slot_entry_t       wdata;
  } ram_req_t;

  // Masks a slot count or ID to the width of the ID fields.
  function automatic logic [PID_W-1:0] to_pid(input logic [CNT_W-1:0] v);
    logic [CNT_W+PID_W-1:0] ext;
    ext = (CNT_W + PID_W)'(v);
    return ext[PID_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/srtf_preemptive_scheduler_core.sv =====
// Shortest-remaining-time-first scheduler, top level: sequencer, process table
// memory and output register. Depends on srtf_pkg, srtf_slot_ram, srtf_engine.
//
// Usage: each input transfer on in_valid/in_ready carries one item. An add
// item (mode 0) registers a process in the next free slot, or is rejected
// when the table is full or the burst is zero; a tick item (mode 1) runs the
// ready process with the least remaining time for one unit and advances time.
// Every item yields exactly one result on out_valid/out_ready.
// Flow: an add item goes from the engine's result register to the output
// register through the emit state. A tick item scans the table one slot per
// cycle through the memory read port, then passes the update, accumulate and
// emit states before its result is loaded into the output register. Items
// are handled one at a time; in_ready is high only between items.
// Reset (rst_n low, synchronous) empties the table, clears time, the
// completion count and both totals.
// When the receiver stalls, the result waits in the output register; the
// block finishes the next item and then holds it until the register frees.
`default_nettype none

module srtf_preemptive_scheduler_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire srtf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output srtf_pkg::out_item_t      out_data
);

  srtf_pkg::ram_req_t    ram_req;
  srtf_pkg::slot_entry_t ram_rdata;
  logic                  res_free;
  logic                  res_valid;
  srtf_pkg::out_item_t   res;

  logic                  out_valid_r, out_valid_nxt;
  srtf_pkg::out_item_t   out_data_r;

  srtf_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  srtf_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/srtf_slot_ram.sv =====
// Process table: one synchronous single-port memory holding arrival, burst,
// remaining time and done flag per slot. Depends on srtf_pkg.
`default_nettype none

module srtf_slot_ram (
  input  wire logic               clk,
  input  wire srtf_pkg::ram_req_t req,
  output srtf_pkg::slot_entry_t   rdata
);

  srtf_pkg::slot_entry_t mem [srtf_pkg::NUM_SLOTS];
  srtf_pkg::slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/srtf_engine.sv =====
// Scheduling sequencer: registers processes, scans the table for the shortest
// remaining time, updates the winner and builds the result. Depends on srtf_pkg.
`default_nettype none

module srtf_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire srtf_pkg::in_item_t    in_data,
  output srtf_pkg::ram_req_t         ram_req,
  input  wire srtf_pkg::slot_entry_t ram_rdata,
  input  wire logic                  res_free,
  output logic                       res_valid,
  output srtf_pkg::out_item_t        res
);

  localparam int IW = srtf_pkg::IDX_W;
  localparam int CW = srtf_pkg::CNT_W;
  localparam int TW = srtf_pkg::TIME_W;
  localparam int PW = srtf_pkg::PID_W;
  localparam int SW = srtf_pkg::SUM_W;
  localparam logic [CW-1:0] SlotsFull = CW'(srtf_pkg::NUM_SLOTS);

  srtf_pkg::state_t      state_r, state_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [TW-1:0]         time_r, time_nxt;
  logic [PW-1:0]         prev_r, prev_nxt;
  logic [CW-1:0]         done_cnt_r, done_cnt_nxt;
  logic [SW-1:0]         wsum_r, wsum_nxt;
  logic [SW-1:0]         tsum_r, tsum_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  srtf_pkg::slot_entry_t best_r, best_nxt;
  logic                  fin_r, fin_nxt;
  logic [TW-1:0]         tat_r, tat_nxt;
  srtf_pkg::out_item_t   res_r, res_nxt;

  logic                  cand;
  logic [TW-1:0]         new_rem;
  logic [TW:0]           end_time;
  logic [TW:0]           tat_full;
  logic [TW-1:0]         wt;
  logic [PW-1:0]         runner;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= srtf_pkg::ST_IDLE;
      occ_r      <= '0;
      time_r     <= '0;
      prev_r     <= '0;
      done_cnt_r <= '0;
      wsum_r     <= '0;
      tsum_r     <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      occ_r      <= occ_nxt;
      time_r     <= time_nxt;
      prev_r     <= prev_nxt;
      done_cnt_r <= done_cnt_nxt;
      wsum_r     <= wsum_nxt;
      tsum_r     <= tsum_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    fin_r      <= fin_nxt;
    tat_r      <= tat_nxt;
    res_r      <= res_nxt;
  end

  // A read issued in one cycle returns data for comparison in the next.
  assign cand = rd_pend_r && !ram_rdata.done && (ram_rdata.arrival <= time_r) &&
                (!found_r || (ram_rdata.remaining < best_r.remaining) ||
                 ((ram_rdata.remaining == best_r.remaining) &&
                  (ram_rdata.arrival >= best_r.arrival)));

  assign new_rem  = (best_r.remaining != '0) ? best_r.remaining - TW'(1) : '0;
  assign end_time = {1'b0, time_r} + (TW + 1)'(1);
  // The winner has already arrived, so this difference never goes negative.
  assign tat_full = end_time - {1'b0, best_r.arrival};
  assign wt       = (tat_r >= best_r.burst) ? tat_r - best_r.burst : '0;
  assign runner   = found_r ? srtf_pkg::to_pid(CW'({1'b0, best_idx_r}) + CW'(1)) : '0;

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    time_nxt     = time_r;
    prev_nxt     = prev_r;
    done_cnt_nxt = done_cnt_r;
    wsum_nxt     = wsum_r;
    tsum_nxt     = tsum_r;
    scan_nxt     = scan_r;
    rd_pend_nxt  = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    fin_nxt      = fin_r;
    tat_nxt      = tat_r;
    res_nxt      = res_r;
    ram_req      = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt                  = '0;
          res_nxt.tick_time        = time_r;
          res_nxt.done_count       = srtf_pkg::to_pid(done_cnt_r);
          res_nxt.total_waiting    = wsum_r;
          res_nxt.total_turnaround = tsum_r;
          if (in_data.mode == srtf_pkg::MODE_ADD) begin
            state_nxt = srtf_pkg::ST_EMIT;
            if (occ_r >= SlotsFull) begin
              res_nxt.status = srtf_pkg::STATUS_FULL;
            end else if (in_data.burst_time == '0) begin
              res_nxt.status = srtf_pkg::STATUS_ZERO_BURST;
            end else begin
              res_nxt.status            = srtf_pkg::STATUS_OK;
              res_nxt.process_id        = srtf_pkg::to_pid(occ_r + CW'(1));
              ram_req.we                = 1'b1;
              ram_req.addr              = occ_r[IW-1:0];
              ram_req.wdata.arrival     = in_data.arrival_time;
              ram_req.wdata.burst       = in_data.burst_time;
              ram_req.wdata.remaining   = in_data.burst_time;
              ram_req.wdata.done        = 1'b0;
              occ_nxt                   = occ_r + CW'(1);
            end
          end else begin
            state_nxt = srtf_pkg::ST_SCAN;
            scan_nxt  = '0;
            found_nxt = 1'b0;
          end
        end
      end

      srtf_pkg::ST_SCAN: begin
        if (cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = ram_rdata;
        end
        if (scan_r != occ_r) begin
          ram_req.re  = 1'b1;
          ram_req.addr = scan_r[IW-1:0];
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = scan_r[IW-1:0];
          scan_nxt    = scan_r + CW'(1);
        end else if (!rd_pend_r) begin
          state_nxt = srtf_pkg::ST_UPDATE;
        end
      end

      srtf_pkg::ST_UPDATE: begin
        fin_nxt   = 1'b0;
        tat_nxt   = '0;
        state_nxt = srtf_pkg::ST_ACCUM;
        if (found_r) begin
          ram_req.we              = 1'b1;
          ram_req.addr            = best_idx_r;
          ram_req.wdata           = best_r;
          ram_req.wdata.remaining = new_rem;
          ram_req.wdata.done      = (new_rem == '0);
          if (new_rem == '0) begin
            fin_nxt = 1'b1;
            // Completion at the time ceiling can reach 65536; clamp it.
            tat_nxt = tat_full[TW] ? {TW{1'b1}} : tat_full[TW-1:0];
          end
        end
      end

      srtf_pkg::ST_ACCUM: begin
        res_nxt             = '0;
        res_nxt.status      = srtf_pkg::STATUS_OK;
        res_nxt.process_id  = runner;
        res_nxt.tick_time   = time_r;
        res_nxt.new_segment = (runner != prev_r);
        res_nxt.finished    = fin_r;
        if (fin_r) begin
          res_nxt.turnaround = tat_r;
          res_nxt.waiting    = wt;
          wsum_nxt           = srtf_pkg::sat_add(wsum_r, wt);
          tsum_nxt           = srtf_pkg::sat_add(tsum_r, tat_r);
          if (done_cnt_r < SlotsFull) begin
            done_cnt_nxt = done_cnt_r + CW'(1);
          end
        end
        res_nxt.done_count       = srtf_pkg::to_pid(done_cnt_nxt);
        res_nxt.total_waiting    = wsum_nxt;
        res_nxt.total_turnaround = tsum_nxt;
        prev_nxt = runner;
        if (time_r != {TW{1'b1}}) begin
          time_nxt = time_r + TW'(1);
        end
        state_nxt = srtf_pkg::ST_EMIT;
      end

      srtf_pkg::ST_EMIT: begin
        res_valid = res_free;
        if (res_free) begin
          state_nxt = srtf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== verif/tb_srtf_preemptive_scheduler_core.sv =====
// Testbench for srtf_preemptive_scheduler_core: a directed test, random traffic under
// several idling patterns, output back-pressure, wide field ranges and a full table.
// Depends on srtf_pkg and the scheduler RTL; each result is checked against a predictor.
`default_nettype none

module tb_srtf_preemptive_scheduler_core;

  localparam longint RUN_LIMIT = 64'd60_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  srtf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  srtf_pkg::out_item_t out_data;

  srtf_preemptive_scheduler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Predicted scheduler state.
  logic [srtf_pkg::TIME_W-1:0] proc_arrival [srtf_pkg::NUM_SLOTS];
  logic [srtf_pkg::TIME_W-1:0] proc_burst   [srtf_pkg::NUM_SLOTS];
  logic [srtf_pkg::TIME_W-1:0] proc_left    [srtf_pkg::NUM_SLOTS];
  logic                        proc_done    [srtf_pkg::NUM_SLOTS] = '{default: 1'b0};
  int unsigned                 slots_used = 0;
  logic [srtf_pkg::TIME_W-1:0] now_time = '0;
  int unsigned                 last_runner = 0;
  int unsigned                 done_total = 0;
  logic [srtf_pkg::SUM_W-1:0]  wait_total = '0;
  logic [srtf_pkg::SUM_W-1:0]  tat_total = '0;

  srtf_pkg::out_item_t pending_outcomes [$];
  int                  error_count = 0;
  int                  results_seen = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_request = 0;
  int hold_off_left = 0;

  function automatic logic [srtf_pkg::SUM_W-1:0] clamp_add(
    input logic [srtf_pkg::SUM_W-1:0] acc, input int unsigned inc);
    logic [srtf_pkg::SUM_W:0] s;
    s = {1'b0, acc} + (srtf_pkg::SUM_W + 1)'(inc);
    return s[srtf_pkg::SUM_W] ? {srtf_pkg::SUM_W{1'b1}} : s[srtf_pkg::SUM_W-1:0];
  endfunction

  // Applies one accepted item to the predicted state and returns its result.
  function automatic srtf_pkg::out_item_t predict_srtf_step(input srtf_pkg::in_item_t item);
    srtf_pkg::out_item_t r;
    int                  i;
    int                  best;
    bit                  found;
    int unsigned         runner;
    int unsigned         endt;
    int unsigned         tat;
    int unsigned         wt;
    r = '0;
    r.tick_time = now_time;
    if (item.mode == srtf_pkg::MODE_ADD) begin
      if (slots_used >= srtf_pkg::NUM_SLOTS) begin
        r.status = srtf_pkg::STATUS_FULL;
      end else if (item.burst_time == '0) begin
        r.status = srtf_pkg::STATUS_ZERO_BURST;
      end else begin
        proc_arrival[slots_used] = item.arrival_time;
        proc_burst[slots_used]   = item.burst_time;
        proc_left[slots_used]    = item.burst_time;
        proc_done[slots_used]    = 1'b0;
        slots_used++;
        r.status     = srtf_pkg::STATUS_OK;
        r.process_id = srtf_pkg::PID_W'(slots_used);
      end
    end else begin
      found  = 1'b0;
      best   = 0;
      runner = 0;
      for (i = 0; i < slots_used; i++) begin
        if (!proc_done[i] && proc_arrival[i] <= now_time) begin
          // Equal remaining time goes to the later arrival; on a full tie the
          // scan order hands it to the higher ID.
          if (!found || proc_left[i] < proc_left[best] ||
              (proc_left[i] == proc_left[best] &&
               proc_arrival[i] >= proc_arrival[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        runner = best + 1;
        if (proc_left[best] != '0) proc_left[best] = proc_left[best] - 1'b1;
        if (proc_left[best] == '0) begin
          // Once time has stalled at its maximum the completion counts as one past it.
          endt = int'(now_time) + 1;
          tat  = (endt >= proc_arrival[best]) ? endt - proc_arrival[best] : 0;
          if (tat > 65535) tat = 65535;
          wt   = (tat >= proc_burst[best]) ? tat - proc_burst[best] : 0;
          proc_done[best] = 1'b1;
          r.finished   = 1'b1;
          r.turnaround = tat[srtf_pkg::TIME_W-1:0];
          r.waiting    = wt[srtf_pkg::TIME_W-1:0];
          if (done_total < srtf_pkg::NUM_SLOTS) done_total++;
          wait_total = clamp_add(wait_total, wt);
          tat_total  = clamp_add(tat_total, tat);
        end
      end
      r.process_id  = srtf_pkg::PID_W'(runner);
      r.new_segment = (runner != last_runner);
      last_runner   = runner;
      if (now_time != '1) now_time = now_time + 1'b1;
    end
    r.done_count       = srtf_pkg::PID_W'(done_total);
    r.total_waiting    = wait_total;
    r.total_turnaround = tat_total;
    return r;
  endfunction

  function automatic srtf_pkg::in_item_t make_tick();
    srtf_pkg::in_item_t t;
    t.mode         = srtf_pkg::MODE_TICK;
    t.arrival_time = srtf_pkg::TIME_W'($urandom);
    t.burst_time   = srtf_pkg::TIME_W'($urandom);
    return t;
  endfunction

  function automatic srtf_pkg::in_item_t make_add(input logic [srtf_pkg::TIME_W-1:0] arrival,
                                                  input logic [srtf_pkg::TIME_W-1:0] burst);
    srtf_pkg::in_item_t t;
    t.mode         = srtf_pkg::MODE_ADD;
    t.arrival_time = arrival;
    t.burst_time   = burst;
    return t;
  endfunction

  task automatic report_mismatch(input string text);
    error_count++;
    $display("ERROR at %0t: %s", $time, text);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, field, got, want));
  endtask

  // Offers one item after an optional random gap and waits for its transfer.
  task automatic send_item(input srtf_pkg::in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(predict_srtf_step(item));
  endtask

  always @(posedge clk) begin : receiver
    if (hold_off_request > 0) begin
      hold_off_left    = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    srtf_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", 64'(out_data.status), 64'(want.status));
        check_field("process_id", 64'(out_data.process_id), 64'(want.process_id));
        check_field("tick_time", 64'(out_data.tick_time), 64'(want.tick_time));
        check_field("new_segment", 64'(out_data.new_segment), 64'(want.new_segment));
        check_field("finished", 64'(out_data.finished), 64'(want.finished));
        check_field("turnaround", 64'(out_data.turnaround), 64'(want.turnaround));
        check_field("waiting", 64'(out_data.waiting), 64'(want.waiting));
        check_field("done_count", 64'(out_data.done_count), 64'(want.done_count));
        check_field("total_waiting", 64'(out_data.total_waiting),
                    64'(want.total_waiting));
        check_field("total_turnaround", 64'(out_data.total_turnaround),
                    64'(want.total_turnaround));
      end
    end
  end

  // Mostly ticks with a sprinkling of adds. Below the wide setting, adds stop at the
  // occupancy cap and arrivals cluster around the current time so that processes
  // actually compete; the wide setting uses the full field ranges.
  task automatic random_traffic(input int items, input int idle, input int stall,
                                input int unsigned cap, input bit wide_fields);
    srtf_pkg::in_item_t          item;
    int unsigned                 pick;
    int unsigned                 r;
    int unsigned                 soon;
    logic [srtf_pkg::TIME_W-1:0] arr;
    logic [srtf_pkg::TIME_W-1:0] burst;
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if ((slots_used < cap || wide_fields) && pick < (wide_fields ? 30 : 18)) begin
        r = $urandom_range(0, 99);
        if (wide_fields) begin
          arr = srtf_pkg::TIME_W'($urandom_range(0, 65535));
        end else if (r < 70) begin
          soon = int'(now_time) + $urandom_range(0, 40);
          arr  = (soon > 65535) ? 16'hFFFF : soon[srtf_pkg::TIME_W-1:0];
        end else if (r < 85) begin
          arr = srtf_pkg::TIME_W'($urandom_range(0, int'(now_time)));
        end else begin
          arr = srtf_pkg::TIME_W'($urandom_range(0, 65535));
        end
        r = $urandom_range(0, 99);
        if (r < 8) burst = '0;
        else if (wide_fields)
          burst = (r < 54) ? srtf_pkg::TIME_W'($urandom_range(1, 6)) :
                             srtf_pkg::TIME_W'($urandom_range(0, 65535));
        else
          burst = (r < 80) ? srtf_pkg::TIME_W'($urandom_range(1, 24)) :
                             srtf_pkg::TIME_W'($urandom_range(25, 300));
        item = make_add(arr, burst);
      end else if (pick < 3) begin
        // A zero burst is always rejected, so it leaves the table alone.
        item = make_add(srtf_pkg::TIME_W'($urandom_range(0, 65535)), '0);
      end else begin
        item = make_tick();
      end
      send_item(item);
    end
  endtask

  task automatic test_directed_scheduling();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(make_tick());
    send_item(make_add(16'hFFFF, 16'h0000));
    send_item(make_add(16'd1, 16'd4));
    send_item(make_add(16'd2, 16'd3));
    send_item(make_add(16'd2, 16'd3));
    // Early ticks see later arrivals not yet present; then equal remaining times tie
    // on arrival and on ID, a preemption happens and all three complete, and the
    // last two ticks find nothing to run.
    repeat (12) send_item(make_tick());
    send_item(make_add(16'h0000, 16'hFFFF));
    send_item(make_tick());
  endtask

  task automatic test_random_no_idle();
    random_traffic(300, 0, 0, 6, 1'b0);
  endtask

  task automatic test_random_sender_gaps();
    random_traffic(300, 88, 0, 7, 1'b0);
  endtask

  task automatic test_random_receiver_stalls();
    random_traffic(300, 0, 88, 8, 1'b0);
  endtask

  task automatic test_random_both_idle();
    random_traffic(300, 26, 26, 9, 1'b0);
  endtask

  // The receiver holds off while items keep coming, so the block fills and stalls.
  task automatic test_input_backpressure();
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_off_request = 400;
    repeat (12) send_item(make_tick());
    send_item(make_add(16'd0, 16'd0));
  endtask

  task automatic test_saturated_random();
    random_traffic(150, 26, 26, srtf_pkg::NUM_SLOTS, 1'b1);
  endtask

  task automatic test_full_table();
    send_idle_pct = 0;
    stall_pct     = 0;
    while (slots_used < srtf_pkg::NUM_SLOTS)
      send_item(make_add(srtf_pkg::TIME_W'($urandom_range(0, 65535)),
                         srtf_pkg::TIME_W'($urandom_range(1, 65535))));
    send_item(make_add(16'd5, 16'd7));
    // A full table is reported ahead of a zero burst.
    send_item(make_add(16'd5, 16'd0));
    repeat (3) send_item(make_tick());
  endtask

  initial begin : main_sequence
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_scheduling();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_input_backpressure();
    test_random_both_idle();
    test_saturated_random();
    test_full_table();
    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (k = 0; k < 200000 && pending_outcomes.size() != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_outcomes.size()));
    if (error_count == 0) begin
      $display("** srtf_preemptive_scheduler_core: PASSED **");
    end else begin
      $display("** srtf_preemptive_scheduler_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("** srtf_preemptive_scheduler_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
